### rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants for the sampled closest approach block
// Widths of the datapath, command and status bundles between the controller
// and the datapath, and the controller's state type.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

  localparam int POS_W   = 20;
  localparam int VEL_W   = 16;
  localparam int DP_W    = POS_W + 1;
  localparam int DV_W    = VEL_W + 1;
  localparam int MAG_W   = 16;
  localparam int DIVD_W  = MAG_W + 8;
  localparam int Q_W     = 17;
  localparam int COORD_W = DP_W + 1;
  localparam int AMAG_W  = 21;
  localparam int SQ_W    = 2 * AMAG_W;
  localparam int DIST_W  = SQ_W + 1;
  localparam int OUT_W   = 22;
  localparam int RAD_W   = 2 * OUT_W;
  localparam int REM_W   = OUT_W + 2;

  localparam int SAMPLE_LIMIT = 128;
  localparam int CNT_W        = $clog2(SAMPLE_LIMIT + 1);

  localparam logic [DIST_W-1:0] START_MIN = DIST_W'(64'd6553600000000);
  localparam logic [OUT_W-1:0]  MAX_OUT   = OUT_W'(2560000);
  localparam logic [MAG_W-1:0]  SLOW_MAX  = MAG_W'(256);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SAMPLE,
    ST_DRAIN,
    ST_SQRT_WAIT,
    ST_FINISH
  } scp_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic smp_init;
    logic smp_step;
    logic sqrt_start;
    logic out_load;
  } scp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic smp_last;
    logic pipe_busy;
    logic sqrt_busy;
  } scp_sts_t;

endpackage

`default_nettype wire

### rtl/sampled_closest_approach.sv
// ----------------------------------------------------------------------------
// sampled_closest_approach: closest sampled distance of two moving points
// Samples the relative position of two objects at equal fractions of one
// frame and returns the square root of the smallest squared distance.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    two positions, two velocities
//   out_     output     out_valid/out_stall  min_distance, Q14.8
//
// An item passes through the 24-step offset divider, then the
// one-sample-per-cycle loop over n samples (1 to 128), then the 22-step
// square root. Reset clears the controller and the busy, valid and count
// registers of the units only. The next item is taken while a finished
// result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sampled_closest_approach (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [scp_pkg::POS_W-1:0]   in_first_pos_x,
  input  wire logic signed [scp_pkg::POS_W-1:0]   in_first_pos_y,
  input  wire logic signed [scp_pkg::VEL_W-1:0]   in_first_vel_x,
  input  wire logic signed [scp_pkg::VEL_W-1:0]   in_first_vel_y,
  input  wire logic signed [scp_pkg::POS_W-1:0]   in_second_pos_x,
  input  wire logic signed [scp_pkg::POS_W-1:0]   in_second_pos_y,
  input  wire logic signed [scp_pkg::VEL_W-1:0]   in_second_vel_x,
  input  wire logic signed [scp_pkg::VEL_W-1:0]   in_second_vel_y,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [scp_pkg::OUT_W-1:0]               out_min_distance
);

  scp_pkg::scp_cmd_t cmd;
  scp_pkg::scp_sts_t sts;

  scp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  scp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .first_pos_x  (in_first_pos_x),
    .first_pos_y  (in_first_pos_y),
    .first_vel_x  (in_first_vel_x),
    .first_vel_y  (in_first_vel_y),
    .second_pos_x (in_second_pos_x),
    .second_pos_y (in_second_pos_y),
    .second_vel_x (in_second_vel_x),
    .second_vel_y (in_second_vel_y),
    .min_distance (out_min_distance)
  );

endmodule

`default_nettype wire

### rtl/scp_div.sv
// ----------------------------------------------------------------------------
// scp_div: restoring divider for the per-sample offset step
// Produces one quotient bit per cycle; gives quotient and remainder of a
// scaled velocity difference divided by the largest velocity component.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [scp_pkg::DIVD_W-1:0]   dividend,
  input  wire logic [scp_pkg::MAG_W-1:0]    divisor,
  output logic                              busy,
  output logic [scp_pkg::DIVD_W-1:0]        quotient,
  output logic [scp_pkg::MAG_W-1:0]         remainder
);

  localparam int ITER_W = $clog2(scp_pkg::DIVD_W + 1);

  logic                        busy_r, busy_nxt;
  logic [ITER_W-1:0]           iter_r, iter_nxt;
  logic [scp_pkg::DIVD_W-1:0]  quo_r, quo_nxt;
  logic [scp_pkg::MAG_W-1:0]   rem_r, rem_nxt;
  logic [scp_pkg::MAG_W-1:0]   dsr_r, dsr_nxt;
  logic [scp_pkg::MAG_W:0]     shifted;
  logic [scp_pkg::MAG_W:0]     diff;

  always_comb begin
    busy_nxt = busy_r;
    iter_nxt = iter_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    shifted  = {rem_r, quo_r[scp_pkg::DIVD_W-1]};
    diff     = shifted - {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = ITER_W'(scp_pkg::DIVD_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = diff[scp_pkg::MAG_W-1:0];
        quo_nxt = {quo_r[scp_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[scp_pkg::MAG_W-1:0];
        quo_nxt = {quo_r[scp_pkg::DIVD_W-2:0], 1'b0};
      end
      iter_nxt = iter_r - ITER_W'(1);
      if (iter_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      iter_r <= iter_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### rtl/scp_isqrt.sv
// ----------------------------------------------------------------------------
// scp_isqrt: iterative integer square root
// Takes two radicand bits per cycle and settles one root bit per cycle,
// giving the truncated square root of the smallest squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [scp_pkg::DIST_W-1:0]  radicand,
  output logic                             busy,
  output logic [scp_pkg::OUT_W-1:0]        root
);

  localparam int ITER_W = $clog2(scp_pkg::OUT_W + 1);

  logic                         busy_r, busy_nxt;
  logic [ITER_W-1:0]            iter_r, iter_nxt;
  logic [scp_pkg::RAD_W-1:0]    rad_r, rad_nxt;
  logic [scp_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [scp_pkg::OUT_W-1:0]    root_r, root_nxt;
  logic [scp_pkg::REM_W+1:0]    rem_sh;
  logic [scp_pkg::REM_W+1:0]    trial;
  logic [scp_pkg::REM_W+1:0]    diff;

  always_comb begin
    busy_nxt = busy_r;
    iter_nxt = iter_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r, rad_r[scp_pkg::RAD_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    diff     = rem_sh - trial;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = ITER_W'(scp_pkg::OUT_W);
      rad_nxt  = {{(scp_pkg::RAD_W - scp_pkg::DIST_W){1'b0}}, radicand};
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      if (rem_sh >= trial) begin
        rem_nxt  = diff[scp_pkg::REM_W-1:0];
        root_nxt = {root_r[scp_pkg::OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[scp_pkg::REM_W-1:0];
        root_nxt = {root_r[scp_pkg::OUT_W-2:0], 1'b0};
      end
      rad_nxt  = {rad_r[scp_pkg::RAD_W-3:0], 2'b00};
      iter_nxt = iter_r - ITER_W'(1);
      if (iter_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      iter_r <= iter_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

`default_nettype wire

### rtl/scp_dp.sv
// ----------------------------------------------------------------------------
// scp_dp: datapath of the sampled closest approach block
// Holds the relative motion, steps the sample offsets by quotient and
// remainder, squares and compares samples in a short pipeline, and takes
// the square root of the minimum into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire scp_pkg::scp_cmd_t                  cmd,
  output scp_pkg::scp_sts_t                       sts,
  input  wire logic signed [scp_pkg::POS_W-1:0]   first_pos_x,
  input  wire logic signed [scp_pkg::POS_W-1:0]   first_pos_y,
  input  wire logic signed [scp_pkg::VEL_W-1:0]   first_vel_x,
  input  wire logic signed [scp_pkg::VEL_W-1:0]   first_vel_y,
  input  wire logic signed [scp_pkg::POS_W-1:0]   second_pos_x,
  input  wire logic signed [scp_pkg::POS_W-1:0]   second_pos_y,
  input  wire logic signed [scp_pkg::VEL_W-1:0]   second_vel_x,
  input  wire logic signed [scp_pkg::VEL_W-1:0]   second_vel_y,
  output logic [scp_pkg::OUT_W-1:0]               min_distance
);

  logic signed [scp_pkg::DP_W-1:0]  dpx_r, dpy_r;
  logic [scp_pkg::MAG_W-1:0]        dvx_mag_r, dvy_mag_r;
  logic                             dvx_neg_r, dvy_neg_r;
  logic [scp_pkg::MAG_W-1:0]        m_r;

  logic signed [scp_pkg::DV_W-1:0]  dvx, dvy;
  logic [scp_pkg::DV_W-1:0]         dvx_abs, dvy_abs;
  logic [scp_pkg::MAG_W-1:0]        m1x, m1y, m2x, m2y, m_a, m_b, m_max;

  logic [scp_pkg::DIVD_W-1:0]       quo_x, quo_y;
  logic [scp_pkg::MAG_W-1:0]        rem_x, rem_y;
  logic                             busy_x, busy_y;

  logic [scp_pkg::Q_W-1:0]          qx_r, qy_r, qx_nxt, qy_nxt;
  logic [scp_pkg::MAG_W-1:0]        rx_r, ry_r, rx_nxt, ry_nxt;
  logic [scp_pkg::MAG_W:0]          rx_sum, ry_sum, rx_sub, ry_sub;
  logic [scp_pkg::CNT_W-1:0]        cnt_r;
  logic [scp_pkg::MAG_W:0]          m_round;
  logic [scp_pkg::MAG_W-8:0]        n_raw;
  logic [scp_pkg::CNT_W-1:0]        n_samples;

  logic signed [scp_pkg::COORD_W-1:0] cx, cy;
  logic [scp_pkg::COORD_W-1:0]        cx_abs, cy_abs;
  logic [scp_pkg::AMAG_W-1:0]         ax_r, ay_r;
  logic [scp_pkg::SQ_W-1:0]           sqx_r, sqy_r;
  logic [scp_pkg::DIST_W-1:0]         sample_sq;
  logic [scp_pkg::DIST_W-1:0]         best_r;
  logic                               v1_r, v2_r;

  logic                               sqrt_busy;
  logic [scp_pkg::OUT_W-1:0]          root;
  logic [scp_pkg::OUT_W-1:0]          out_r;

  function automatic logic [scp_pkg::MAG_W-1:0] vmag(input logic signed [scp_pkg::VEL_W-1:0] v);
    logic [scp_pkg::VEL_W:0] e;
    e = v[scp_pkg::VEL_W-1] ? -{v[scp_pkg::VEL_W-1], v} : {v[scp_pkg::VEL_W-1], v};
    return e[scp_pkg::MAG_W-1:0];
  endfunction

  assign dvx     = {first_vel_x[scp_pkg::VEL_W-1], first_vel_x}
                 - {second_vel_x[scp_pkg::VEL_W-1], second_vel_x};
  assign dvy     = {first_vel_y[scp_pkg::VEL_W-1], first_vel_y}
                 - {second_vel_y[scp_pkg::VEL_W-1], second_vel_y};
  assign dvx_abs = dvx[scp_pkg::DV_W-1] ? -dvx : dvx;
  assign dvy_abs = dvy[scp_pkg::DV_W-1] ? -dvy : dvy;

  assign m1x   = vmag(first_vel_x);
  assign m1y   = vmag(first_vel_y);
  assign m2x   = vmag(second_vel_x);
  assign m2y   = vmag(second_vel_y);
  assign m_a   = (m1y > m1x) ? m1y : m1x;
  assign m_b   = (m2y > m2x) ? m2y : m2x;
  assign m_max = (m_b > m_a) ? m_b : m_a;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dpx_r     <= {first_pos_x[scp_pkg::POS_W-1], first_pos_x}
                 - {second_pos_x[scp_pkg::POS_W-1], second_pos_x};
      dpy_r     <= {first_pos_y[scp_pkg::POS_W-1], first_pos_y}
                 - {second_pos_y[scp_pkg::POS_W-1], second_pos_y};
      dvx_mag_r <= dvx_abs[scp_pkg::MAG_W-1:0];
      dvy_mag_r <= dvy_abs[scp_pkg::MAG_W-1:0];
      dvx_neg_r <= dvx[scp_pkg::DV_W-1];
      dvy_neg_r <= dvy[scp_pkg::DV_W-1];
      m_r       <= m_max;
    end
  end

  scp_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  ({dvx_mag_r, 8'h00}),
    .divisor   (m_r),
    .busy      (busy_x),
    .quotient  (quo_x),
    .remainder (rem_x)
  );

  scp_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  ({dvy_mag_r, 8'h00}),
    .divisor   (m_r),
    .busy      (busy_y),
    .quotient  (quo_y),
    .remainder (rem_y)
  );

  assign m_round   = {1'b0, m_r} + (scp_pkg::MAG_W + 1)'(255);
  assign n_raw     = m_round[scp_pkg::MAG_W:8];
  assign n_samples = (m_r <= scp_pkg::SLOW_MAX) ? scp_pkg::CNT_W'(1) :
                     ((scp_pkg::CNT_W + 1)'(n_raw) > (scp_pkg::CNT_W + 1)'(scp_pkg::SAMPLE_LIMIT))
                     ? scp_pkg::CNT_W'(scp_pkg::SAMPLE_LIMIT)
                     : scp_pkg::CNT_W'(n_raw);

  always_comb begin
    rx_sum = {1'b0, rx_r} + {1'b0, rem_x};
    ry_sum = {1'b0, ry_r} + {1'b0, rem_y};
    rx_sub = rx_sum - {1'b0, m_r};
    ry_sub = ry_sum - {1'b0, m_r};
    if (rx_sum >= {1'b0, m_r}) begin
      rx_nxt = rx_sub[scp_pkg::MAG_W-1:0];
      qx_nxt = qx_r + quo_x[scp_pkg::Q_W-1:0] + scp_pkg::Q_W'(1);
    end else begin
      rx_nxt = rx_sum[scp_pkg::MAG_W-1:0];
      qx_nxt = qx_r + quo_x[scp_pkg::Q_W-1:0];
    end
    if (ry_sum >= {1'b0, m_r}) begin
      ry_nxt = ry_sub[scp_pkg::MAG_W-1:0];
      qy_nxt = qy_r + quo_y[scp_pkg::Q_W-1:0] + scp_pkg::Q_W'(1);
    end else begin
      ry_nxt = ry_sum[scp_pkg::MAG_W-1:0];
      qy_nxt = qy_r + quo_y[scp_pkg::Q_W-1:0];
    end
  end

  assign cx = dvx_neg_r ? ({dpx_r[scp_pkg::DP_W-1], dpx_r} - $signed({5'b0, qx_r}))
                        : ({dpx_r[scp_pkg::DP_W-1], dpx_r} + $signed({5'b0, qx_r}));
  assign cy = dvy_neg_r ? ({dpy_r[scp_pkg::DP_W-1], dpy_r} - $signed({5'b0, qy_r}))
                        : ({dpy_r[scp_pkg::DP_W-1], dpy_r} + $signed({5'b0, qy_r}));
  assign cx_abs    = cx[scp_pkg::COORD_W-1] ? -cx : cx;
  assign cy_abs    = cy[scp_pkg::COORD_W-1] ? -cy : cy;
  assign sample_sq = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      v1_r <= cmd.smp_step;
      v2_r <= v1_r;
      if (cmd.smp_init) begin
        cnt_r <= n_samples;
      end else if (cmd.smp_step) begin
        cnt_r <= cnt_r - scp_pkg::CNT_W'(1);
      end
    end
    if (cmd.smp_init) begin
      qx_r   <= '0;
      qy_r   <= '0;
      rx_r   <= '0;
      ry_r   <= '0;
      best_r <= scp_pkg::START_MIN;
    end else begin
      if (cmd.smp_step) begin
        qx_r <= qx_nxt;
        qy_r <= qy_nxt;
        rx_r <= rx_nxt;
        ry_r <= ry_nxt;
      end
      if (v2_r && (sample_sq < best_r)) begin
        best_r <= sample_sq;
      end
    end
    ax_r  <= cx_abs[scp_pkg::AMAG_W-1:0];
    ay_r  <= cy_abs[scp_pkg::AMAG_W-1:0];
    sqx_r <= ax_r * ax_r;
    sqy_r <= ay_r * ay_r;
  end

  scp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (best_r),
    .busy     (sqrt_busy),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= (root > scp_pkg::MAX_OUT) ? scp_pkg::MAX_OUT : root;
    end
  end

  assign min_distance  = out_r;
  assign sts.div_busy  = busy_x | busy_y;
  assign sts.smp_last  = (cnt_r == scp_pkg::CNT_W'(1));
  assign sts.pipe_busy = v1_r | v2_r;
  assign sts.sqrt_busy = sqrt_busy;

endmodule

`default_nettype wire

### rtl/scp_ctrl.sv
// ----------------------------------------------------------------------------
// scp_ctrl: controller of the sampled closest approach block
// Sequences capture, division, sampling, pipeline drain and square root,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output scp_pkg::scp_cmd_t        cmd,
  input  wire scp_pkg::scp_sts_t   sts
);

  scp_pkg::scp_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    case (state_r)
      scp_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = scp_pkg::ST_DIV_START;
        end
      end
      scp_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        cmd.smp_init  = 1'b1;
        state_nxt     = scp_pkg::ST_DIV_WAIT;
      end
      scp_pkg::ST_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = scp_pkg::ST_SAMPLE;
        end
      end
      scp_pkg::ST_SAMPLE: begin
        cmd.smp_step = 1'b1;
        if (sts.smp_last) begin
          state_nxt = scp_pkg::ST_DRAIN;
        end
      end
      scp_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = scp_pkg::ST_SQRT_WAIT;
        end
      end
      scp_pkg::ST_SQRT_WAIT: begin
        if (!sts.sqrt_busy) begin
          state_nxt = scp_pkg::ST_FINISH;
        end
      end
      scp_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = scp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != scp_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### verif/sampled_closest_approach_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sampled_closest_approach_tb: self-checking bench for closest approach
// Sends pairs of moving objects through the input channel: a directed set
// first, then random pairs, three in ten of them placed so that the objects pass
// close to each other within the frame. Each accepted item is predicted
// here, and every result is checked in order against those predictions.
// Both sides idle and stall in random bursts until the closing stretch.
// ----------------------------------------------------------------------------

module sampled_closest_approach_tb;
  import scp_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] p1x;
    logic signed [POS_W-1:0] p1y;
    logic signed [VEL_W-1:0] v1x;
    logic signed [VEL_W-1:0] v1y;
    logic signed [POS_W-1:0] p2x;
    logic signed [POS_W-1:0] p2y;
    logic signed [VEL_W-1:0] v2x;
    logic signed [VEL_W-1:0] v2y;
  } pair_t;

  localparam int RANDOM_PAIRS = 1550;
  localparam int CALM_TAIL    = 120;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [POS_W-1:0] in_first_pos_x = '0;
  logic signed [POS_W-1:0] in_first_pos_y = '0;
  logic signed [VEL_W-1:0] in_first_vel_x = '0;
  logic signed [VEL_W-1:0] in_first_vel_y = '0;
  logic signed [POS_W-1:0] in_second_pos_x = '0;
  logic signed [POS_W-1:0] in_second_pos_y = '0;
  logic signed [VEL_W-1:0] in_second_vel_x = '0;
  logic signed [VEL_W-1:0] in_second_vel_y = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [OUT_W-1:0]        out_min_distance;

  pair_t            pairs_to_send[$];
  logic [OUT_W-1:0] expected_distance_q[$];
  pair_t            pair_on_bus;
  logic [OUT_W-1:0] wanted_distance;
  int               send_idle_left = 0;
  int               recv_stall_left = 0;
  int               mismatch_count = 0;

  sampled_closest_approach i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_pos_x   (in_first_pos_x),
    .in_first_pos_y   (in_first_pos_y),
    .in_first_vel_x   (in_first_vel_x),
    .in_first_vel_y   (in_first_vel_y),
    .in_second_pos_x  (in_second_pos_x),
    .in_second_pos_y  (in_second_pos_y),
    .in_second_vel_x  (in_second_vel_x),
    .in_second_vel_y  (in_second_vel_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_min_distance (out_min_distance)
  );

  always #5 clk = ~clk;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Relative coordinate at sample k of a frame divided into vmax/256 steps.
  function automatic longint coord_at_sample(longint dp, longint dv, longint k,
                                             longint vmax);
    longint offset;
    if (k == 0 || vmax == 0) begin
      return dp;
    end
    offset = (magnitude(dv) * k * 256) / vmax;
    return (dv < 0) ? dp - offset : dp + offset;
  endfunction

  function automatic logic [OUT_W-1:0] closest_distance(pair_t p);
    longint dpx, dpy, dvx, dvy, vmax, best, ax, ay, sq, root, trial;
    dpx  = longint'($signed(p.p1x)) - longint'($signed(p.p2x));
    dpy  = longint'($signed(p.p1y)) - longint'($signed(p.p2y));
    dvx  = longint'($signed(p.v1x)) - longint'($signed(p.v2x));
    dvy  = longint'($signed(p.v1y)) - longint'($signed(p.v2y));
    vmax = magnitude(longint'($signed(p.v1x)));
    if (magnitude(longint'($signed(p.v1y))) > vmax) vmax = magnitude(longint'($signed(p.v1y)));
    if (magnitude(longint'($signed(p.v2x))) > vmax) vmax = magnitude(longint'($signed(p.v2x)));
    if (magnitude(longint'($signed(p.v2y))) > vmax) vmax = magnitude(longint'($signed(p.v2y)));
    best = 64'd6553600000000;
    for (longint k = 0; k < SAMPLE_LIMIT && (k == 0 || k * 256 < vmax); k++) begin
      ax = magnitude(coord_at_sample(dpx, dvx, k, vmax));
      ay = magnitude(coord_at_sample(dpy, dvy, k, vmax));
      sq = ax * ax + ay * ay;
      if (sq < best) best = sq;
    end
    root = 0;
    for (int b = OUT_W; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= best) root = trial;
    end
    if (root > longint'(MAX_OUT)) root = longint'(MAX_OUT);
    return OUT_W'(root);
  endfunction

  task automatic queue_pair(longint p1x, longint p1y, longint v1x, longint v1y,
                            longint p2x, longint p2y, longint v2x, longint v2y);
    pair_t p;
    p.p1x = POS_W'(p1x);
    p.p1y = POS_W'(p1y);
    p.v1x = VEL_W'(v1x);
    p.v1y = VEL_W'(v1y);
    p.p2x = POS_W'(p2x);
    p.p2y = POS_W'(p2y);
    p.v2x = VEL_W'(v2x);
    p.v2y = VEL_W'(v2y);
    pairs_to_send.push_back(p);
  endtask

  function automatic longint spread(int unsigned r);
    return longint'($urandom_range(0, 2 * r)) - longint'(r);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      send_idle_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_distance_q.push_back(closest_distance(pair_on_bus));
      end
      if (!in_valid || !in_stall) begin
        if (send_idle_left > 0) begin
          send_idle_left <= send_idle_left - 1;
          in_valid       <= 1'b0;
        end else if (pairs_to_send.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
          send_idle_left <= $urandom_range(0, 13);
          in_valid       <= 1'b0;
        end else if (pairs_to_send.size() > 0) begin
          pair_on_bus     = pairs_to_send.pop_front();
          in_first_pos_x  <= pair_on_bus.p1x;
          in_first_pos_y  <= pair_on_bus.p1y;
          in_first_vel_x  <= pair_on_bus.v1x;
          in_first_vel_y  <= pair_on_bus.v1y;
          in_second_pos_x <= pair_on_bus.p2x;
          in_second_pos_y <= pair_on_bus.p2y;
          in_second_vel_x <= pair_on_bus.v2x;
          in_second_vel_y <= pair_on_bus.v2y;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall       <= 1'b0;
      recv_stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_distance_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no item outstanding", out_min_distance));
        end else begin
          wanted_distance = expected_distance_q.pop_front();
          if (out_min_distance !== wanted_distance) begin
            report_mismatch($sformatf("min_distance %0d, expected %0d",
                                      out_min_distance, wanted_distance));
          end
        end
      end
      if (recv_stall_left > 0) begin
        recv_stall_left <= recv_stall_left - 1;
        out_stall       <= 1'b1;
      end else if (pairs_to_send.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        recv_stall_left <= $urandom_range(0, 13);
        out_stall       <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
    int unsigned frac;

    // The directed set covers field extremes, slow and exactly-at-threshold
    // speeds, the full sample count and passes along both axes.
    queue_pair(0, 0, 0, 0, 0, 0, 0, 0);
    queue_pair(524287, 524287, 0, 0, -524288, -524288, 0, 0);
    queue_pair(-524288, -524288, 32767, -32768, 524287, 524287, -32768, 32767);
    queue_pair(524287, -524288, -32768, -32768, -524288, 524287, -32768, -32768);
    queue_pair(-524288, -524288, -32768, -32768, -524288, -524288, -32768, -32768);
    queue_pair(1234, -777, 32767, 32767, 1234, -777, 32767, 32767);
    queue_pair(-1000, 0, 256, 0, 0, 0, 0, 0);
    queue_pair(-1000, 0, -257, 0, 0, 0, 0, 0);
    queue_pair(300, 400, 0, 0, 0, 0, 0, 0);
    queue_pair(-5000, 0, 10000, 0, 0, 0, 0, 0);
    queue_pair(-30000, 17, 32767, 0, 0, 0, -32768, 0);
    queue_pair(0, 20000, 0, -8000, 0, 0, 0, 300);
    queue_pair(50, -60, 0, 0, 0, 0, 0, 32767);
    queue_pair(-70, 90, 0, 0, 0, 0, -32768, 0);
    queue_pair(0, 0, 0, 255, 0, 0, -1, 0);
    queue_pair(16000, 16000, -32768, -32768, 0, 0, 32767, 32767);
    queue_pair(-1, -1, 1, -1, 0, 0, 0, 0);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          queue_pair(longint'($signed(POS_W'($urandom()))), longint'($signed(POS_W'($urandom()))),
                     longint'($signed(VEL_W'($urandom()))), longint'($signed(VEL_W'($urandom()))),
                     longint'($signed(POS_W'($urandom()))), longint'($signed(POS_W'($urandom()))),
                     longint'($signed(VEL_W'($urandom()))), longint'($signed(VEL_W'($urandom()))));
        end
        2, 3, 4: begin
          p1x = spread(400000);
          p1y = spread(400000);
          queue_pair(p1x, p1y, spread(32767), spread(32767),
                     p1x + spread(65536), p1y + spread(65536), spread(32767), spread(32767));
        end
        5, 6: begin
          p1x = spread(8000);
          p1y = spread(8000);
          queue_pair(p1x, p1y, spread(260), spread(260),
                     spread(8000), spread(8000), spread(260), spread(260));
        end
        default: begin
          p1x  = spread(400000);
          p1y  = spread(400000);
          v1x  = spread(32767);
          v1y  = spread(32767);
          v2x  = spread(32767);
          v2y  = spread(32767);
          frac = $urandom_range(0, 255);
          p2x  = p1x + (((v1x - v2x) * frac) >>> 8) + spread(64);
          p2y  = p1y + (((v1y - v2y) * frac) >>> 8) + spread(64);
          queue_pair(p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y);
        end
      endcase
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pairs_to_send.size() != 0 || in_valid) @(posedge clk);
    while (expected_distance_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("sampled_closest_approach regression: pass");
    end else begin
      $display("sampled_closest_approach regression: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", expected_distance_q.size());
    $display("sampled_closest_approach regression: fail");
    $finish;
  end

endmodule
